>>> sv/fixed_point_alu_macros.svh
// assertion helpers for the fixed point alu
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH

// check a property on every rising clock edge outside reset
`define FXA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check an implication on every rising clock edge outside reset
`define FXA_IMPLIES(label, cond, prop, msg) \
    `FXA_ASSERT(label, (cond) |-> (prop), msg)

`endif

>>> sv/fxa_pkg.sv
// ----------------------------------------------------------------------------
// fxa_pkg
// Types and constants shared by the fixed point alu modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fxa_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_FRAC_BITS = 16;
    localparam int DEF_FRAC_BITS = 8;
    localparam int DVD_W         = DATA_W + MAX_FRAC_BITS;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int IN_TDATA_W    = 72;
    localparam int OUT_TDATA_W   = 40;

    localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_GT    = 4'd4,
        OP_LT    = 4'd5,
        OP_GE    = 4'd6,
        OP_LE    = 4'd7,
        OP_EQ    = 4'd8,
        OP_NE    = 4'd9,
        OP_MIN   = 4'd10,
        OP_MAX   = 4'd11,
        OP_INC   = 4'd12,
        OP_DEC   = 4'd13,
        OP_TOINT = 4'd14
    } op_t;

    // one word in flight through the divider row
    typedef struct packed {
        logic              valid;
        op_t               op;
        logic              neg;
        logic [DATA_W-1:0] res;
        logic              cmp;
        logic              ovf;
        logic              dz;
        logic [PROD_W-1:0] prod;
        logic [DATA_W-1:0] den;
        logic [DATA_W-1:0] rem;
        logic [DVD_W-1:0]  dvd;
        logic [DVD_W-1:0]  quo;
    } pipe_t;

    typedef struct packed {
        logic [DATA_W-1:0] res;
        logic              cmp;
        logic              ovf;
        logic              dz;
    } result_t;

endpackage

>>> sv/fxa_cell.sv
// ----------------------------------------------------------------------------
// fxa_cell
// One restoring divide step: produces one quotient bit per word per cycle while adv is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fxa_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  fxa_pkg::pipe_t din,
    output fxa_pkg::pipe_t dout
);

    fxa_pkg::pipe_t         stage_reg;
    fxa_pkg::pipe_t         stage_next;
    logic [fxa_pkg::DATA_W:0] shifted;
    logic [fxa_pkg::DATA_W:0] diff;

    always_comb
    begin
        stage_next = din;
        shifted    = {din.rem, din.dvd[fxa_pkg::DVD_W-1]};
        diff       = shifted - {1'b0, din.den};
        if (din.op == fxa_pkg::OP_DIV && !din.dz)
        begin
            stage_next.dvd = {din.dvd[fxa_pkg::DVD_W-2:0], 1'b0};
            if (shifted >= {1'b0, din.den})
            begin
                stage_next.rem = diff[fxa_pkg::DATA_W-1:0];
                stage_next.quo = {din.quo[fxa_pkg::DVD_W-2:0], 1'b1};
            end
            else
            begin
                stage_next.rem = shifted[fxa_pkg::DATA_W-1:0];
                stage_next.quo = {din.quo[fxa_pkg::DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (adv)
        begin
            stage_reg <= stage_next;
        end
    end

    assign dout = stage_reg;

endmodule

>>> sv/fxa_round.sv
// ----------------------------------------------------------------------------
// fxa_round
// Rounds multiply and divide magnitudes, applies sign and saturates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fxa_round
#(
    parameter int FRACTION_BITS = fxa_pkg::DEF_FRAC_BITS
)
(
    input  fxa_pkg::pipe_t   din,
    output fxa_pkg::result_t dout
);

    localparam logic [fxa_pkg::PROD_W-1:0] HALF = fxa_pkg::PROD_W'(1) << (FRACTION_BITS - 1);

    logic [fxa_pkg::PROD_W-1:0] qmag;
    logic                       rbit;
    logic                       rounded_op;

    always_comb
    begin
        rbit       = {din.rem, 1'b0} >= {1'b0, din.den};
        rounded_op = (din.op == fxa_pkg::OP_MUL) || (din.op == fxa_pkg::OP_DIV && !din.dz);
        if (din.op == fxa_pkg::OP_MUL)
        begin
            qmag = (din.prod + HALF) >> FRACTION_BITS;
        end
        else
        begin
            qmag = fxa_pkg::PROD_W'(din.quo) + fxa_pkg::PROD_W'(rbit);
        end

        dout = '{res: din.res, cmp: din.cmp, ovf: din.ovf, dz: din.dz};
        if (rounded_op)
        begin
            if (!din.neg)
            begin
                if (qmag > fxa_pkg::PROD_W'(fxa_pkg::MAX_POS))
                begin
                    dout.res = fxa_pkg::MAX_POS;
                    dout.ovf = 1'b1;
                end
                else
                begin
                    dout.res = qmag[fxa_pkg::DATA_W-1:0];
                end
            end
            else
            begin
                if (qmag > fxa_pkg::PROD_W'(fxa_pkg::MIN_NEG))
                begin
                    dout.res = fxa_pkg::MIN_NEG;
                    dout.ovf = 1'b1;
                end
                else
                begin
                    dout.res = -qmag[fxa_pkg::DATA_W-1:0];
                end
            end
        end
    end

endmodule

>>> sv/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed fixed point alu: arithmetic, compares, min/max and integer conversion.
// ----------------------------------------------------------------------------
// Input words arrive on s_tvalid/s_tready/s_tdata, each an opcode with two
// signed operands of FRACTION_BITS fraction bits. Every word gives exactly one
// result word on m_tvalid/m_tready/m_tdata, in order.
// Every opcode takes the same path: an input stage
// (decode, adders, 32x32 magnitude multiplier), a row of 32 + FRACTION_BITS
// divide cells each producing one quotient bit, and the output register
// where rounding and saturation land.
// Throughput is one word per cycle. The whole row moves together; it moves
// whenever the output register is empty or being taken, so s_tready drops
// only while a result waits and m_tready is low. Nothing is lost in a stall.
// Reset clears every stage; no result is shown until a word has gone through.
// Divide by zero saturates by the dividend sign and sets divide_by_zero;
// any other saturation sets overflow_flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fixed_point_alu_macros.svh"

module fixed_point_alu
#(
    parameter int FRACTION_BITS = fxa_pkg::DEF_FRAC_BITS
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // operation[3:0], operand_a[35:4], operand_b[67:36], zero pad
    input  logic [fxa_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // result_value[31:0], compare_true[32], overflow_flag[33],
    // divide_by_zero[34], zero pad
    output logic [fxa_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int NCELLS = fxa_pkg::DATA_W + FRACTION_BITS;
    localparam int PAD_W  = fxa_pkg::OUT_TDATA_W - fxa_pkg::DATA_W - 3;

    fxa_pkg::pipe_t   chain [NCELLS+1];
    fxa_pkg::pipe_t   front_next;
    fxa_pkg::pipe_t   front_reg;
    fxa_pkg::result_t rounded;
    fxa_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             adv;

    logic signed [fxa_pkg::DATA_W-1:0] a;
    logic signed [fxa_pkg::DATA_W-1:0] b;
    logic [fxa_pkg::DATA_W-1:0]        amag;
    logic [fxa_pkg::DATA_W-1:0]        bmag;
    logic [fxa_pkg::DATA_W:0]          sum;
    logic [fxa_pkg::DATA_W:0]          dif;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign a        = s_tdata[fxa_pkg::DATA_W+3:4];
    assign b        = s_tdata[2*fxa_pkg::DATA_W+3:fxa_pkg::DATA_W+4];
    assign amag     = a[fxa_pkg::DATA_W-1] ? -a : a;
    assign bmag     = b[fxa_pkg::DATA_W-1] ? -b : b;

    // input stage: everything but divide and rounding settles here
    always_comb
    begin
        front_next       = '0;
        front_next.valid = s_tvalid;
        front_next.op    = fxa_pkg::op_t'(s_tdata[3:0]);
        front_next.neg   = a[fxa_pkg::DATA_W-1] ^ b[fxa_pkg::DATA_W-1];
        front_next.prod  = amag * bmag;
        front_next.den   = bmag;
        front_next.dvd   = {amag, {fxa_pkg::MAX_FRAC_BITS{1'b0}}};
        sum = {a[fxa_pkg::DATA_W-1], a};
        dif = {a[fxa_pkg::DATA_W-1], a};
        case (front_next.op)
            fxa_pkg::OP_ADD, fxa_pkg::OP_INC:
            begin
                if (front_next.op == fxa_pkg::OP_ADD)
                    sum = {a[fxa_pkg::DATA_W-1], a} + {b[fxa_pkg::DATA_W-1], b};
                else
                    sum = {a[fxa_pkg::DATA_W-1], a} + (fxa_pkg::DATA_W+1)'(1);
                if (sum[fxa_pkg::DATA_W] != sum[fxa_pkg::DATA_W-1])
                begin
                    front_next.ovf = 1'b1;
                    front_next.res = sum[fxa_pkg::DATA_W] ? fxa_pkg::MIN_NEG : fxa_pkg::MAX_POS;
                end
                else
                    front_next.res = sum[fxa_pkg::DATA_W-1:0];
            end
            fxa_pkg::OP_SUB, fxa_pkg::OP_DEC:
            begin
                if (front_next.op == fxa_pkg::OP_SUB)
                    dif = {a[fxa_pkg::DATA_W-1], a} - {b[fxa_pkg::DATA_W-1], b};
                else
                    dif = {a[fxa_pkg::DATA_W-1], a} - (fxa_pkg::DATA_W+1)'(1);
                if (dif[fxa_pkg::DATA_W] != dif[fxa_pkg::DATA_W-1])
                begin
                    front_next.ovf = 1'b1;
                    front_next.res = dif[fxa_pkg::DATA_W] ? fxa_pkg::MIN_NEG : fxa_pkg::MAX_POS;
                end
                else
                    front_next.res = dif[fxa_pkg::DATA_W-1:0];
            end
            fxa_pkg::OP_MUL: ;
            fxa_pkg::OP_DIV:
            begin
                if (b == '0)
                begin
                    front_next.dz  = 1'b1;
                    front_next.res = a[fxa_pkg::DATA_W-1] ? fxa_pkg::MIN_NEG : fxa_pkg::MAX_POS;
                end
            end
            fxa_pkg::OP_GT:    front_next.cmp = a > b;
            fxa_pkg::OP_LT:    front_next.cmp = a < b;
            fxa_pkg::OP_GE:    front_next.cmp = a >= b;
            fxa_pkg::OP_LE:    front_next.cmp = a <= b;
            fxa_pkg::OP_EQ:    front_next.cmp = a == b;
            fxa_pkg::OP_NE:    front_next.cmp = a != b;
            fxa_pkg::OP_MIN:   front_next.res = (a > b) ? b : a;
            fxa_pkg::OP_MAX:   front_next.res = (a < b) ? b : a;
            fxa_pkg::OP_TOINT: front_next.res = a >>> FRACTION_BITS;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
        end
        else if (adv)
        begin
            front_reg <= front_next;
        end
    end

    assign chain[0] = front_reg;

    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        fxa_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    fxa_round #(.FRACTION_BITS(FRACTION_BITS)) u_round
    (
        .din  (chain[NCELLS]),
        .dout (rounded)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (adv)
        begin
            out_valid_reg <= chain[NCELLS].valid;
            out_reg       <= rounded;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_reg.dz, out_reg.ovf, out_reg.cmp, out_reg.res};

    `FXA_IMPLIES(a_accept_enters, s_tvalid && s_tready, ##1 front_reg.valid, "accepted word did not enter the row")
    `FXA_IMPLIES(a_dz_no_ovf, m_tvalid, !(out_reg.dz && out_reg.ovf), "divide by zero also flagged overflow")
    `FXA_IMPLIES(a_cmp_zero_res, m_tvalid && out_reg.cmp, out_reg.res == '0, "compare result carries a value")

endmodule
